// ===== src/signed_int_to_decimal_ascii_macros.svh =====
// Assertion macros used by the checker of this block.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SIDA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sida check failed");

// Consequent must hold in the cycle after the antecedent.
`define SIDA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sida check failed");

`endif

// ===== src/sida_pkg.sv =====
`default_nettype none

package sida_pkg;

  // Output character encoding
  localparam int CHAR_W = 6;
  localparam int OUT_TDATA_W = 8;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;

  // One BCD digit, and binary bits folded into the digits per cycle
  localparam int DIGIT_W = 4;
  localparam int BITS_PER_STEP = 4;

  // Entries in the queue between conversion and character output
  localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

// ===== src/signed_int_to_decimal_ascii.sv =====
// Front: accepts an item only while idle, so it takes no new item until it has handed
// the last one to the queue; the work is done by the 4-bit-per-cycle shift-add-3
// converter. Back: one character per cycle while the output is not stalled, and it fetches
// a number from the queue between numbers; a two-entry queue lets the two overlap.
// Reset (rst_n low, synchronous) empties the queue and drops any item in flight.
`default_nettype none

module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [VALUE_BITS-1:0] value, zero padding above to whole bytes
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0]     in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [5:0] character, [7:6] zero
  output logic [sida_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic                                     out_tlast
);

  localparam int DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int IDX_W = $clog2(DIGITS);
  localparam int BCD_W = DIGITS * sida_pkg::DIGIT_W;
  localparam int ENTRY_W = 1 + IDX_W + BCD_W;

  logic               f_valid;
  logic               f_ready;
  logic               f_neg;
  logic [IDX_W-1:0]   f_top;
  logic [BCD_W-1:0]   f_bcd;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;
  logic               b_valid;
  logic               b_ready;

  sida_front #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS),
    .IDX_W      (IDX_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_value  (in_tdata[VALUE_BITS-1:0]),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_neg     (f_neg),
    .q_top     (f_top),
    .q_bcd     (f_bcd)
  );

  assign wr_data = {f_neg, f_top, f_bcd};

  sida_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (wr_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (rd_data)
  );

  sida_back #(
    .DIGITS (DIGITS),
    .IDX_W  (IDX_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (b_valid),
    .q_ready    (b_ready),
    .q_neg      (rd_data[ENTRY_W-1]),
    .q_top      (rd_data[BCD_W +: IDX_W]),
    .q_bcd      (rd_data[BCD_W-1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== src/sida_front.sv =====
`default_nettype none

module sida_front #(
  parameter int VALUE_BITS = 32,
  parameter int DIGITS = 10,
  parameter int IDX_W = 4
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [VALUE_BITS-1:0]                in_value,
  output logic                                      q_valid,
  input  wire logic                                 q_ready,
  output logic                                      q_neg,
  output logic [IDX_W-1:0]                          q_top,
  output logic [DIGITS*sida_pkg::DIGIT_W-1:0]       q_bcd
);

  localparam int STEPS = (VALUE_BITS + sida_pkg::BITS_PER_STEP - 1) / sida_pkg::BITS_PER_STEP;
  localparam int SH_W = STEPS * sida_pkg::BITS_PER_STEP;
  localparam int BCD_W = DIGITS * sida_pkg::DIGIT_W;
  localparam int STEP_W = $clog2(STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PUSH
  } state_t;

  state_t              state_r;
  logic                neg_r;
  logic [SH_W-1:0]     sh_r;
  logic [SH_W-1:0]     sh_nxt;
  logic [BCD_W-1:0]    bcd_r;
  logic [BCD_W-1:0]    bcd_nxt;
  logic [STEP_W-1:0]   step_r;
  logic [VALUE_BITS-1:0] mag;
  logic [IDX_W-1:0]    top;

  // Magnitude as unsigned; the most negative value maps onto itself
  always_comb begin
    if (in_value[VALUE_BITS-1]) begin
      mag = ~in_value + VALUE_BITS'(1);
    end else begin
      mag = in_value;
    end
  end

  // Shift-add-3 conversion, several binary bits per cycle
  always_comb begin
    bcd_nxt = bcd_r;
    sh_nxt = sh_r;
    for (int k = 0; k < sida_pkg::BITS_PER_STEP; k++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (bcd_nxt[d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] >= 4'd5) begin
          bcd_nxt[d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] =
            bcd_nxt[d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] + 4'd3;
        end
      end
      bcd_nxt = {bcd_nxt[BCD_W-2:0], sh_nxt[SH_W-1]};
      sh_nxt = {sh_nxt[SH_W-2:0], 1'b0};
    end
  end

  // Locate the leading nonzero digit; zero keeps digit position zero
  always_comb begin
    top = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd_r[d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] != '0) begin
        top = IDX_W'(d);
      end
    end
  end

  // Accept, convert, then hand the result to the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            neg_r   <= in_value[VALUE_BITS-1];
            sh_r    <= SH_W'(mag);
            bcd_r   <= '0;
            step_r  <= STEP_W'(STEPS - 1);
            state_r <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd_r <= bcd_nxt;
          sh_r  <= sh_nxt;
          if (step_r == '0) begin
            state_r <= ST_PUSH;
          end else begin
            step_r <= step_r - STEP_W'(1);
          end
        end
        ST_PUSH: begin
          if (q_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign q_valid = (state_r == ST_PUSH);
  assign q_neg = neg_r;
  assign q_top = top;
  assign q_bcd = bcd_r;

endmodule

`default_nettype wire

// ===== src/sida_queue.sv =====
`default_nettype none

module sida_queue #(
  parameter int WIDTH = 46
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);

  localparam int DEPTH = sida_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push;
  logic             pop;

  assign wr_ready = (cnt_r != CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  // Store an entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/sida_back.sv =====
`default_nettype none

module sida_back #(
  parameter int DIGITS = 10,
  parameter int IDX_W = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_valid,
  output logic                                  q_ready,
  input  wire logic                             q_neg,
  input  wire logic [IDX_W-1:0]                 q_top,
  input  wire logic [DIGITS*sida_pkg::DIGIT_W-1:0] q_bcd,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [sida_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                  out_tlast
);

  localparam int BCD_W = DIGITS * sida_pkg::DIGIT_W;
  localparam int PAD_W = sida_pkg::OUT_TDATA_W - sida_pkg::CHAR_W;

  logic                          busy_r;
  logic                          neg_r;
  logic [IDX_W-1:0]              idx_r;
  logic [BCD_W-1:0]              bcd_r;
  logic                          out_tvalid_r;
  logic [sida_pkg::CHAR_W-1:0]   char_r;
  logic                          last_r;
  logic                          out_free;
  logic [sida_pkg::DIGIT_W-1:0]  digit;

  assign q_ready = !busy_r;
  assign out_free = !out_tvalid_r || out_tready;
  assign digit = bcd_r[int'(idx_r)*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W];

  // Pop a number, then emit sign and digits one per cycle unless stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (!busy_r && q_valid) begin
        busy_r <= 1'b1;
        neg_r  <= q_neg;
        idx_r  <= q_top;
        bcd_r  <= q_bcd;
      end
      if (busy_r && out_free) begin
        out_tvalid_r <= 1'b1;
        if (neg_r) begin
          char_r <= sida_pkg::CHAR_MINUS;
          last_r <= 1'b0;
          neg_r  <= 1'b0;
        end else begin
          char_r <= sida_pkg::CHAR_ZERO + sida_pkg::CHAR_W'(digit);
          last_r <= (idx_r == '0);
          if (idx_r == '0) begin
            busy_r <= 1'b0;
          end else begin
            idx_r <= idx_r - IDX_W'(1);
          end
        end
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata = {{PAD_W{1'b0}}, char_r};
  assign out_tlast = last_r;

endmodule

`default_nettype wire

// ===== src/sida_checker.sv =====
`default_nettype none
`include "signed_int_to_decimal_ascii_macros.svh"

module sida_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [sida_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                           out_tlast
);

  // A stalled item holds its character and flag
  `SIDA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // Only a minus sign or a decimal digit leaves, with zero padding
  `SIDA_ASSERT_SAME(a_char_legal, out_tvalid, (out_tdata[7:6] == 2'd0) && ((out_tdata[5:0] == 6'd45) || ((out_tdata[5:0] >= 6'd48) && (out_tdata[5:0] <= 6'd57))))

  // A sign is never the final character
  `SIDA_ASSERT_SAME(a_sign_not_last, out_tvalid && (out_tdata[5:0] == 6'd45), !out_tlast)

  // A taken sign is followed by a digit, never by a second sign
  `SIDA_ASSERT_NEXT(a_sign_then_digit, out_tvalid && out_tready && (out_tdata[5:0] == 6'd45), !(out_tvalid && (out_tdata[5:0] == 6'd45)))

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
